/* src/bqf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package bqf_pkg;

  localparam int unsigned COEF_WIDTH         = 32;
  localparam int unsigned DEF_SAMPLE_WIDTH   = 32;
  localparam int unsigned DEF_COEF_FRAC_BITS = 28;

  // coefficient sums of three taps need two guard bits
  localparam int unsigned MUL_W     = COEF_WIDTH + 2;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [1:0] MODE_FILTER = 2'd0;
  localparam logic [1:0] MODE_PRESET = 2'd1;
  localparam logic [1:0] MODE_BIAS   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_B0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_B1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_A0 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_A1 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_A2 = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_DIV_PREP,
    ST_DIV,
    ST_DIV_FIN,
    ST_BIAS,
    ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    TERM_B0,
    TERM_B1,
    TERM_B2,
    TERM_A1,
    TERM_A2
  } term_e;

endpackage

`default_nettype wire

/* src/biquad_iir_filter_with_bias_shift_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Direct-form-I biquad in fixed point (Q16.16 samples, Q4.28 coefficients), one request at a
// time, built on a bit-serial shift-and-add multiplier and a one-bit-per-cycle restoring
// divider. Once accepted, a filter request (mode 0) runs five products, then a restoring
// divide over the SAMPLE_WIDTH + 36 bit dividend, with prep, rounding and hand-off steps;
// a bias shift (mode 2) runs one product, one divide and a saturating update of the
// history; a preset (mode 1) or an unused mode goes straight to hand-off. A zero divisor
// skips the divide steps. The next request can be taken in the cycle after the result
// leaves the work registers; the output register holds it until the far side takes it.
// A coefficient write presets the whole history to the newest output.
module biquad_iir_filter_with_bias_shift_unit #(
  parameter int unsigned SAMPLE_WIDTH   = bqf_pkg::DEF_SAMPLE_WIDTH,
  parameter int unsigned COEF_FRAC_BITS = bqf_pkg::DEF_COEF_FRAC_BITS
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [bqf_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [bqf_pkg::COEF_WIDTH-1:0]    cfg_data_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [1:0]                        mode_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0]    sample_value_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic signed [SAMPLE_WIDTH-1:0]         filtered_value_o,
  output logic                                   saturated_o
);
  import bqf_pkg::*;

  localparam int unsigned SW    = SAMPLE_WIDTH;
  localparam int unsigned ACC_W = SW + 36;
  localparam int unsigned DEN_W = MUL_W;
  localparam int unsigned Q_W   = SW + 1;
  localparam int unsigned QR_W  = Q_W + 1;
  localparam int unsigned CNT_W = $clog2(ACC_W);

  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MUL_W - 1);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(ACC_W - 1);

  localparam logic [COEF_WIDTH-1:0] COEF_ONE = {{(COEF_WIDTH-1){1'b0}}, 1'b1} << COEF_FRAC_BITS;

  localparam logic [SW-1:0]   SMAX    = {1'b0, {(SW-1){1'b1}}};
  localparam logic [SW-1:0]   SMIN    = {1'b1, {(SW-1){1'b0}}};
  localparam logic [QR_W-1:0] LIM_POS = {3'b000, {(SW-1){1'b1}}};
  localparam logic [QR_W-1:0] LIM_NEG = {3'b001, {(SW-1){1'b0}}};

  function automatic logic [SW:0] sat_add(input logic [SW-1:0] a, input logic [SW-1:0] b);
    logic [SW:0] s;
    s = {a[SW-1], a} + {b[SW-1], b};
    if (s[SW] != s[SW-1]) begin
      return {1'b1, (s[SW] ? SMIN : SMAX)};
    end
    return {1'b0, s[SW-1:0]};
  endfunction

  state_e state_q, state_d;
  term_e  term_q, term_d;
  logic [1:0]       mode_q, mode_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic signed [COEF_WIDTH-1:0] b0_q, b0_d, b1_q, b1_d, b2_q, b2_d;
  logic signed [COEF_WIDTH-1:0] a0_q, a0_d, a1_q, a1_d, a2_q, a2_d;
  logic signed [SW-1:0] x0_q, x0_d, x1_q, x1_d, x2_q, x2_d;
  logic signed [SW-1:0] y0_q, y0_d, y1_q, y1_d, y2_q, y2_d;

  logic signed [SW-1:0]    samp_q, samp_d;
  logic signed [ACC_W-1:0] mcand_q, mcand_d;
  logic [MUL_W-1:0]        mplier_q, mplier_d;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic [DEN_W-1:0]        den_q, den_d;
  logic [DEN_W-1:0]        rem_q, rem_d;
  logic [Q_W-1:0]          quo_q, quo_d;
  logic                    ovf_q, ovf_d;
  logic                    num_neg_q, num_neg_d;
  logic                    den_neg_q, den_neg_d;
  logic [SW-1:0]           bias_q, bias_d;
  logic                    flag_q, flag_d;

  logic          out_valid_q, out_valid_d;
  logic [SW-1:0] out_value_q, out_value_d;
  logic          out_sat_q, out_sat_d;

  logic             in_accept;
  logic             cfg_hit;
  logic [MUL_W-1:0] sum_b, sum_a, den_sel;
  logic [DEN_W:0]   rem_shift;
  logic             div_ge, rnd_up, res_neg;
  logic [QR_W-1:0]  quo_rnd, quo_lim;
  logic             sub_op, last_term;
  logic [SW-1:0]    quot_val;
  logic             quot_wr;
  logic [SW:0]      sa_x0, sa_x1, sa_x2, sa_y0, sa_y1, sa_y2;

  assign in_stall_o       = (state_q != ST_IDLE);
  assign in_accept        = in_valid_i && !in_stall_o;
  assign out_valid_o      = out_valid_q;
  assign filtered_value_o = out_value_q;
  assign saturated_o      = out_sat_q;

  assign sum_b = {{2{b0_q[COEF_WIDTH-1]}}, b0_q} + {{2{b1_q[COEF_WIDTH-1]}}, b1_q}
               + {{2{b2_q[COEF_WIDTH-1]}}, b2_q};
  assign sum_a = {{2{a0_q[COEF_WIDTH-1]}}, a0_q} + {{2{a1_q[COEF_WIDTH-1]}}, a1_q}
               + {{2{a2_q[COEF_WIDTH-1]}}, a2_q};
  assign den_sel = (mode_q == MODE_BIAS) ? sum_a : {{2{a0_q[COEF_WIDTH-1]}}, a0_q};

  // feedback taps enter the sum negated
  assign sub_op    = (mode_q == MODE_FILTER) && (term_q == TERM_A1 || term_q == TERM_A2);
  assign last_term = (mode_q != MODE_FILTER) || (term_q == TERM_A2);

  assign rem_shift = {rem_q, acc_q[ACC_W-1]};
  assign div_ge    = (rem_shift >= {1'b0, den_q});
  assign rnd_up    = ({rem_q, 1'b0} >= {1'b0, den_q});
  assign quo_rnd   = {1'b0, quo_q} + QR_W'(rnd_up);
  assign res_neg   = den_neg_q ^ num_neg_q;
  assign quo_lim   = res_neg ? LIM_NEG : LIM_POS;

  assign sa_x0 = sat_add(x0_q, samp_q);
  assign sa_x1 = sat_add(x1_q, samp_q);
  assign sa_x2 = sat_add(x2_q, samp_q);
  assign sa_y0 = sat_add(y0_q, bias_q);
  assign sa_y1 = sat_add(y1_q, bias_q);
  assign sa_y2 = sat_add(y2_q, bias_q);

  always_comb begin
    state_d     = state_q;
    term_d      = term_q;
    mode_d      = mode_q;
    cnt_d       = cnt_q;
    b0_d = b0_q; b1_d = b1_q; b2_d = b2_q;
    a0_d = a0_q; a1_d = a1_q; a2_d = a2_q;
    x0_d = x0_q; x1_d = x1_q; x2_d = x2_q;
    y0_d = y0_q; y1_d = y1_q; y2_d = y2_q;
    samp_d      = samp_q;
    mcand_d     = mcand_q;
    mplier_d    = mplier_q;
    acc_d       = acc_q;
    den_d       = den_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    ovf_d       = ovf_q;
    num_neg_d   = num_neg_q;
    den_neg_d   = den_neg_q;
    bias_d      = bias_q;
    flag_d      = flag_q;
    out_valid_d = out_valid_q;
    out_value_d = out_value_q;
    out_sat_d   = out_sat_q;
    quot_val    = '0;
    quot_wr     = 1'b0;
    cfg_hit     = 1'b0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          mode_d = mode_i;
          samp_d = sample_value_i;
          flag_d = 1'b0;
          term_d = TERM_B0;
          acc_d  = '0;
          case (mode_i)
            MODE_FILTER: begin
              x2_d    = x1_q;
              x1_d    = x0_q;
              x0_d    = sample_value_i;
              y2_d    = y1_q;
              y1_d    = y0_q;
              state_d = ST_LOAD;
            end
            MODE_PRESET: begin
              x0_d = sample_value_i; x1_d = sample_value_i; x2_d = sample_value_i;
              y0_d = sample_value_i; y1_d = sample_value_i; y2_d = sample_value_i;
              state_d = ST_DONE;
            end
            MODE_BIAS: begin
              state_d = ST_LOAD;
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end

      ST_LOAD: begin
        cnt_d = '0;
        if (mode_q == MODE_BIAS) begin
          mcand_d  = {{(ACC_W-SW){samp_q[SW-1]}}, samp_q};
          mplier_d = sum_b;
        end else begin
          case (term_q)
            TERM_B0: begin
              mcand_d  = {{(ACC_W-SW){x0_q[SW-1]}}, x0_q};
              mplier_d = {{2{b0_q[COEF_WIDTH-1]}}, b0_q};
            end
            TERM_B1: begin
              mcand_d  = {{(ACC_W-SW){x1_q[SW-1]}}, x1_q};
              mplier_d = {{2{b1_q[COEF_WIDTH-1]}}, b1_q};
            end
            TERM_B2: begin
              mcand_d  = {{(ACC_W-SW){x2_q[SW-1]}}, x2_q};
              mplier_d = {{2{b2_q[COEF_WIDTH-1]}}, b2_q};
            end
            TERM_A1: begin
              mcand_d  = {{(ACC_W-SW){y1_q[SW-1]}}, y1_q};
              mplier_d = {{2{a1_q[COEF_WIDTH-1]}}, a1_q};
            end
            default: begin
              mcand_d  = {{(ACC_W-SW){y2_q[SW-1]}}, y2_q};
              mplier_d = {{2{a2_q[COEF_WIDTH-1]}}, a2_q};
            end
          endcase
        end
        state_d = ST_MUL;
      end

      ST_MUL: begin
        // the multiplier's top bit carries negative weight
        if (mplier_q[0]) begin
          if (sub_op ^ (cnt_q == MUL_LAST)) begin
            acc_d = acc_q - mcand_q;
          end else begin
            acc_d = acc_q + mcand_q;
          end
        end
        mcand_d  = mcand_q << 1;
        mplier_d = mplier_q >> 1;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == MUL_LAST) begin
          if (last_term) begin
            state_d = ST_DIV_PREP;
          end else begin
            state_d = ST_LOAD;
            case (term_q)
              TERM_B0: term_d = TERM_B1;
              TERM_B1: term_d = TERM_B2;
              TERM_B2: term_d = TERM_A1;
              default: term_d = TERM_A2;
            endcase
          end
        end
      end

      ST_DIV_PREP: begin
        num_neg_d = acc_q[ACC_W-1];
        acc_d     = acc_q[ACC_W-1] ? -acc_q : acc_q;
        den_neg_d = den_sel[MUL_W-1];
        den_d     = den_sel[MUL_W-1] ? -den_sel : den_sel;
        rem_d     = '0;
        quo_d     = '0;
        ovf_d     = 1'b0;
        cnt_d     = '0;
        if (den_sel == '0) begin
          flag_d  = 1'b1;
          quot_wr = 1'b1;
          if (acc_q == '0) begin
            quot_val = '0;
          end else begin
            quot_val = acc_q[ACC_W-1] ? SMIN : SMAX;
          end
        end else begin
          state_d = ST_DIV;
        end
      end

      ST_DIV: begin
        if (div_ge) begin
          rem_d = DEN_W'(rem_shift - {1'b0, den_q});
        end else begin
          rem_d = rem_shift[DEN_W-1:0];
        end
        acc_d = acc_q << 1;
        quo_d = {quo_q[Q_W-2:0], div_ge};
        // any quotient bit beyond Q_W forces saturation
        ovf_d = ovf_q | quo_q[Q_W-1];
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DIV_LAST) begin
          state_d = ST_DIV_FIN;
        end
      end

      ST_DIV_FIN: begin
        quot_wr = 1'b1;
        if (ovf_q || (quo_rnd > quo_lim)) begin
          flag_d   = 1'b1;
          quot_val = res_neg ? SMIN : SMAX;
        end else if (res_neg) begin
          quot_val = SW'(-quo_rnd);
        end else begin
          quot_val = quo_rnd[SW-1:0];
        end
      end

      ST_BIAS: begin
        x0_d = sa_x0[SW-1:0]; x1_d = sa_x1[SW-1:0]; x2_d = sa_x2[SW-1:0];
        y0_d = sa_y0[SW-1:0]; y1_d = sa_y1[SW-1:0]; y2_d = sa_y2[SW-1:0];
        flag_d = flag_q | sa_x0[SW] | sa_x1[SW] | sa_x2[SW]
               | sa_y0[SW] | sa_y1[SW] | sa_y2[SW];
        state_d = ST_DONE;
      end

      ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_value_d = y0_q;
          out_sat_d   = flag_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (quot_wr) begin
      if (mode_q == MODE_FILTER) begin
        y0_d    = quot_val;
        state_d = ST_DONE;
      end else begin
        bias_d  = quot_val;
        state_d = ST_BIAS;
      end
    end

    if (cfg_we_i) begin
      cfg_hit = 1'b1;
      case (cfg_idx_i)
        REG_B0:  b0_d = cfg_data_i;
        REG_B1:  b1_d = cfg_data_i;
        REG_B2:  b2_d = cfg_data_i;
        REG_A0:  a0_d = cfg_data_i;
        REG_A1:  a1_d = cfg_data_i;
        REG_A2:  a2_d = cfg_data_i;
        default: cfg_hit = 1'b0;
      endcase
      if (cfg_hit) begin
        x0_d = y0_q; x1_d = y0_q; x2_d = y0_q;
        y1_d = y0_q; y2_d = y0_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      term_q      <= TERM_B0;
      mode_q      <= MODE_FILTER;
      cnt_q       <= '0;
      b0_q        <= COEF_ONE;
      b1_q        <= '0;
      b2_q        <= '0;
      a0_q        <= COEF_ONE;
      a1_q        <= '0;
      a2_q        <= '0;
      x0_q        <= '0;
      x1_q        <= '0;
      x2_q        <= '0;
      y0_q        <= '0;
      y1_q        <= '0;
      y2_q        <= '0;
      flag_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      term_q      <= term_d;
      mode_q      <= mode_d;
      cnt_q       <= cnt_d;
      b0_q        <= b0_d;
      b1_q        <= b1_d;
      b2_q        <= b2_d;
      a0_q        <= a0_d;
      a1_q        <= a1_d;
      a2_q        <= a2_d;
      x0_q        <= x0_d;
      x1_q        <= x1_d;
      x2_q        <= x2_d;
      y0_q        <= y0_d;
      y1_q        <= y1_d;
      y2_q        <= y2_d;
      flag_q      <= flag_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    samp_q      <= samp_d;
    mcand_q     <= mcand_d;
    mplier_q    <= mplier_d;
    acc_q       <= acc_d;
    den_q       <= den_d;
    rem_q       <= rem_d;
    quo_q       <= quo_d;
    ovf_q       <= ovf_d;
    num_neg_q   <= num_neg_d;
    den_neg_q   <= den_neg_d;
    bias_q      <= bias_d;
    out_value_q <= out_value_d;
    out_sat_q   <= out_sat_d;
  end

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> in_stall_o)
    else $error("request accepted but block did not go busy");

  a_preset_loads_history: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && !cfg_we_i && mode_i == MODE_PRESET)
      |=> (y0_q == $past(sample_value_i)) && !flag_q)
    else $error("preset did not load output history");

  a_divisor_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (den_q != '0))
    else $error("divide steps running on a zero divisor");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == ST_DONE))
    else $error("result presented outside hand-off");
`endif

endmodule

`default_nettype wire

/* dv/tb_biquad_iir_filter_with_bias_shift_unit.sv */
`timescale 1ns / 1ps

module tb_biquad_iir_filter_with_bias_shift_unit;
  import bqf_pkg::*;

  localparam int SW             = DEF_SAMPLE_WIDTH;
  localparam int HALF_PERIOD    = 6;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int END_WAIT       = 300;
  localparam int RAND_PHASES    = 9;
  localparam int HALF_PHASE     = 25;

  localparam logic [1:0]           MODE_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE6  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE7  = 3'd7;

  typedef logic signed [SW-1:0]         sample_t;
  typedef logic signed [COEF_WIDTH-1:0] coef_t;
  typedef logic signed [127:0]          wide_t;

  localparam sample_t S_MAX   = 32'sh7FFF_FFFF;
  localparam sample_t S_MIN   = 32'sh8000_0000;
  localparam sample_t ONE_Q16 = 32'sh0001_0000;
  localparam coef_t   ONE_Q28 = 32'sh1000_0000;

  typedef struct packed {
    logic [1:0] mode;
    sample_t    sample;
  } sample_req_t;

  typedef struct packed {
    sample_t value;
    logic    sat;
  } filter_res_t;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  logic                  cfg_we   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
  logic [COEF_WIDTH-1:0] cfg_data = '0;

  logic       in_valid     = 1'b0;
  logic       in_stall;
  logic [1:0] mode         = MODE_FILTER;
  sample_t    sample_value = '0;

  logic    out_valid;
  logic    out_stall = 1'b0;
  sample_t filtered_value;
  logic    saturated;

  biquad_iir_filter_with_bias_shift_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .mode_i           (mode),
    .sample_value_i   (sample_value),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .filtered_value_o (filtered_value),
    .saturated_o      (saturated)
  );

  always begin
    #(HALF_PERIOD) clk_i = 1'b1;
    #(HALF_PERIOD) clk_i = 1'b0;
  end

  // filter state mirrored from the block
  coef_t   coef [6];
  sample_t xh   [3];
  sample_t yh   [3];

  sample_req_t sample_requests[$];
  filter_res_t due_results[$];

  logic taken = 1'b0;
  int   errors = 0;
  int   checked = 0;
  int   sat_seen = 0;
  int   cfg_writes = 0;
  int   mode_count [4];

  function automatic wide_t mul_wide(input longint a, input longint b);
    wide_t ea;
    wide_t eb;
    ea = a;
    eb = b;
    return ea * eb;
  endfunction

  // rounded to nearest (ties away from zero), then clipped to the sample range
  function automatic filter_res_t round_div(input wide_t num, input longint den);
    logic [127:0] mag;
    logic [127:0] d;
    logic [127:0] q;
    logic [127:0] r;
    logic         neg;
    filter_res_t  res;
    res.sat = 1'b0;
    mag = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    if (d == 0) begin
      res.sat = 1'b1;
      res.value = (mag == 0) ? sample_t'(0) : ((num < 0) ? S_MIN : S_MAX);
      return res;
    end
    q = mag / d;
    r = mag % d;
    if (r >= d - r) q = q + 1;
    neg = (den < 0) != (num < 0);
    if (q > (neg ? 128'h8000_0000 : 128'h7FFF_FFFF)) begin
      res.sat = 1'b1;
      res.value = neg ? S_MIN : S_MAX;
    end else begin
      res.value = neg ? -q[SW-1:0] : q[SW-1:0];
    end
    return res;
  endfunction

  function automatic filter_res_t sat_add(input longint a, input longint b);
    longint      t;
    filter_res_t res;
    t = a + b;
    res.sat = 1'b0;
    if (t > S_MAX) begin
      res.sat = 1'b1;
      res.value = S_MAX;
    end else if (t < S_MIN) begin
      res.sat = 1'b1;
      res.value = S_MIN;
    end else begin
      res.value = sample_t'(t);
    end
    return res;
  endfunction

  function automatic void preset_history(input sample_t v);
    for (int i = 0; i < 3; i++) begin
      xh[i] = v;
      yh[i] = v;
    end
  endfunction

  function automatic filter_res_t predict_biquad(input sample_req_t rq);
    wide_t       acc;
    longint      sum_b;
    longint      sum_a;
    filter_res_t q;
    filter_res_t t;
    filter_res_t res;
    logic        sat;
    sat = 1'b0;
    case (rq.mode)
      MODE_FILTER: begin
        xh[2] = xh[1];
        xh[1] = xh[0];
        yh[2] = yh[1];
        yh[1] = yh[0];
        xh[0] = rq.sample;
        acc = mul_wide(coef[REG_B0], xh[0]) + mul_wide(coef[REG_B1], xh[1])
            + mul_wide(coef[REG_B2], xh[2]) - mul_wide(coef[REG_A1], yh[1])
            - mul_wide(coef[REG_A2], yh[2]);
        q = round_div(acc, coef[REG_A0]);
        yh[0] = q.value;
        sat = q.sat;
      end
      MODE_PRESET: preset_history(rq.sample);
      MODE_BIAS: begin
        sum_b = coef[REG_B0];
        sum_b += coef[REG_B1];
        sum_b += coef[REG_B2];
        sum_a = coef[REG_A0];
        sum_a += coef[REG_A1];
        sum_a += coef[REG_A2];
        q = round_div(mul_wide(rq.sample, sum_b), sum_a);
        sat = q.sat;
        for (int i = 0; i < 3; i++) begin
          t = sat_add(yh[i], q.value);
          yh[i] = t.value;
          sat |= t.sat;
          t = sat_add(xh[i], rq.sample);
          xh[i] = t.value;
          sat |= t.sat;
        end
      end
      default: ;
    endcase
    res.value = yh[0];
    res.sat = sat;
    return res;
  endfunction

  always @(posedge clk_i) begin : monitor
    sample_req_t rq;
    filter_res_t want;
    logic        progress;
    int          idle;
    if (rst_n) begin
      progress = 1'b0;
      if (cfg_we) begin
        cfg_writes++;
        // out-of-range indexes leave everything alone
        if (cfg_idx <= REG_A2) begin
          coef[cfg_idx] = cfg_data;
          preset_history(yh[0]);
        end
      end
      if (in_valid && !in_stall) begin
        rq.mode = mode;
        rq.sample = sample_value;
        due_results.push_back(predict_biquad(rq));
        mode_count[rq.mode]++;
        void'(sample_requests.pop_front());
        taken = 1'b1;
        progress = 1'b1;
      end
      if (out_valid && !out_stall) begin
        progress = 1'b1;
        if (due_results.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result: value %h sat %b", filtered_value, saturated);
        end else begin
          want = due_results.pop_front();
          checked++;
          if (saturated) sat_seen++;
          if (filtered_value !== want.value || saturated !== want.sat) begin
            errors++;
            if (errors <= 10)
              $display("mismatch on result %0d: expected value %h sat %b, got value %h sat %b",
                       checked, want.value, want.sat, filtered_value, saturated);
          end
        end
      end
      idle = progress ? 0 : idle + 1;
      if (idle >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", idle);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // sender: bursts of requests separated by random gaps
  always @(negedge clk_i) begin : driver
    int burst_left;
    int gap_left;
    if (rst_n) begin
      if (!in_valid || taken) begin
        if (taken) begin
          taken = 1'b0;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 8);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
          end
        end
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (sample_requests.size() != 0) begin
          in_valid <= 1'b1;
          mode <= sample_requests[0].mode;
          sample_value <= sample_requests[0].sample;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: runs of no stall, random stall and solid stall
  always @(negedge clk_i) begin : receiver
    int run_left;
    int level;
    if (rst_n) begin
      if (run_left <= 0) begin
        level = $urandom_range(0, 2);
        run_left = $urandom_range(1, 60);
      end
      run_left--;
      out_stall <= (level == 0) ? 1'b0 : (level == 1) ? 1'($urandom_range(0, 1)) : 1'b1;
    end
  end

  task automatic push_req(input logic [1:0] m, input sample_t s);
    sample_req_t r;
    r.mode = m;
    r.sample = s;
    sample_requests.push_back(r);
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (sample_requests.size() != 0 || due_results.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input coef_t data);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
  endtask

  task automatic close_writes();
    @(negedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_coefs(input coef_t b0, input coef_t b1, input coef_t b2,
                             input coef_t a0, input coef_t a1, input coef_t a2);
    write_reg(REG_B0, b0);
    write_reg(REG_B1, b1);
    write_reg(REG_B2, b2);
    write_reg(REG_A0, a0);
    write_reg(REG_A1, a1);
    write_reg(REG_A2, a2);
    close_writes();
  endtask

  function automatic coef_t extreme_coef();
    case ($urandom_range(0, 4))
      0: return S_MIN;
      1: return S_MAX;
      2: return coef_t'(0);
      3: return ONE_Q28;
      default: return -ONE_Q28;
    endcase
  endfunction

  function automatic coef_t small_tap();
    return coef_t'(int'($urandom_range(0, 32'h0800_0000)) - 32'h0400_0000);
  endfunction

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 9))
      0: return S_MAX;
      1: return S_MIN;
      2, 3, 4, 5: return sample_t'(int'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000);
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic logic [1:0] pick_mode();
    int r;
    r = $urandom_range(0, 19);
    if (r < 15) return MODE_FILTER;
    if (r < 17) return MODE_PRESET;
    if (r < 19) return MODE_BIAS;
    return MODE_UNUSED;
  endfunction

  initial begin
    coef_t c [6];
    coef[REG_B0] = ONE_Q28;
    coef[REG_B1] = '0;
    coef[REG_B2] = '0;
    coef[REG_A0] = ONE_Q28;
    coef[REG_A1] = '0;
    coef[REG_A2] = '0;
    preset_history('0);
    for (int i = 0; i < 4; i++) mode_count[i] = 0;
    repeat (4) @(negedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // identity coefficients out of reset
    push_req(MODE_FILTER, S_MAX);
    push_req(MODE_FILTER, S_MIN);
    push_req(MODE_FILTER, ONE_Q16);
    push_req(MODE_FILTER, -sample_t'(1));
    push_req(MODE_PRESET, 32'sh1234_5678);
    push_req(MODE_UNUSED, sample_t'(-1));
    push_req(MODE_BIAS, S_MAX);
    push_req(MODE_BIAS, S_MIN);
    push_req(MODE_FILTER, 3 * ONE_Q16);
    wait_drained();

    // zero divisor on both the filter and the bias path
    write_coefs(S_MAX, S_MIN, ONE_Q28, '0, '0, '0);
    push_req(MODE_FILTER, ONE_Q16);
    push_req(MODE_PRESET, '0);
    push_req(MODE_FILTER, '0);
    push_req(MODE_BIAS, sample_t'(5));
    wait_drained();

    write_coefs(S_MAX, S_MAX, S_MAX, S_MIN, S_MAX, S_MAX);
    push_req(MODE_FILTER, S_MAX);
    push_req(MODE_FILTER, S_MIN);
    push_req(MODE_BIAS, S_MAX);
    wait_drained();

    // denominator coefficient sum cancels: bias divisor is zero while a0 is not
    write_coefs(ONE_Q28 >>> 1, '0, '0, ONE_Q28, -ONE_Q28, '0);
    push_req(MODE_FILTER, 7 * ONE_Q16);
    push_req(MODE_BIAS, ONE_Q16);
    push_req(MODE_BIAS, '0);
    wait_drained();

    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p % 5)
        0: begin
          c[REG_B0] = small_tap();
          c[REG_B1] = small_tap();
          c[REG_B2] = small_tap();
          c[REG_A0] = ONE_Q28;
          c[REG_A1] = -(ONE_Q28 + coef_t'($urandom_range(0, 241591910)));
          c[REG_A2] = coef_t'($urandom_range(80530637, 241591910));
        end
        1: for (int i = 0; i < 6; i++) c[i] = coef_t'($urandom);
        2: for (int i = 0; i < 6; i++) c[i] = extreme_coef();
        3: begin
          for (int i = 0; i < 6; i++) c[i] = small_tap();
          c[REG_A0] = coef_t'($urandom_range(1, 255));
          if ($urandom_range(0, 1)) c[REG_A0] = -c[REG_A0];
        end
        default: begin
          for (int i = 0; i < 6; i++) c[i] = coef_t'($urandom);
          c[REG_A0] = '0;
        end
      endcase
      write_coefs(c[REG_B0], c[REG_B1], c[REG_B2], c[REG_A0], c[REG_A1], c[REG_A2]);
      for (int k = 0; k < HALF_PHASE; k++) push_req(pick_mode(), pick_sample());
      wait_drained();
      // a write to an unused index must not preset the history
      write_reg($urandom_range(0, 1) ? REG_SPARE6 : REG_SPARE7, coef_t'($urandom));
      close_writes();
      for (int k = 0; k < HALF_PHASE; k++) push_req(pick_mode(), pick_sample());
      wait_drained();
    end

    repeat (END_WAIT) @(negedge clk_i);
    if (due_results.size() != 0) errors++;
    $display("Covered %0d filter, %0d preset, %0d bias-shift and %0d unused-mode requests",
             mode_count[MODE_FILTER], mode_count[MODE_PRESET], mode_count[MODE_BIAS],
             mode_count[MODE_UNUSED]);
    $display("%0d coefficient writes, %0d results checked, %0d flagged as saturated",
             cfg_writes, checked, sat_seen);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
